>>> sv/wbd_pkg.sv
// Package for the walkability block downsampler.
// Holds the configuration register indexes, the field widths and the
// control struct passed from the position tracker to the accumulator.
package wbd_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] REG_RAW_WIDTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_STEP = 1'd1;

    localparam int RAW_CELL_W  = 8;
    localparam int RAW_WIDTH_W = 11;
    localparam int GRID_STEP_W = 5;
    localparam int COORD_W     = 10;

    typedef struct packed {
        logic               walk;
        logic               in_range;
        logic               first_row;
        logic               emit;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } pos_ctrl_t;

endpackage

>>> sv/wbd_ifs.sv
// Channel interfaces for the walkability block downsampler.
// Depends on wbd_pkg for the field widths.
interface wbd_raw_if;
    logic                           valid;
    logic                           ready;
    logic [wbd_pkg::RAW_CELL_W-1:0] raw_cell;
    logic                           frame_start;

    modport source (output valid, output raw_cell, output frame_start, input ready);
    modport sink (input valid, input raw_cell, input frame_start, output ready);
endinterface

interface wbd_cell_if;
    logic                        valid;
    logic                        ready;
    logic                        cell_walkable;
    logic [wbd_pkg::COORD_W-1:0] cell_x;
    logic [wbd_pkg::COORD_W-1:0] cell_y;

    modport source (output valid, output cell_walkable, output cell_x, output cell_y,
                     input ready);
    modport sink (input valid, input cell_walkable, input cell_x, input cell_y,
                   output ready);
endinterface

interface wbd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [wbd_pkg::CFG_INDEX_W-1:0] index;
    logic [wbd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/wbd_position.sv
// Raster position tracker of the walkability block downsampler.
// Keeps the raw and coarse counters and classifies each accepted cell.
// Depends on wbd_pkg for the control struct.
module wbd_position #(
    parameter int MAX_RAW_WIDTH   = 1024,
    parameter int MAX_BLOCK_SIDE  = 16,
    parameter int MAX_COARSE_ROWS = 1024,
    localparam int RCW = $clog2(MAX_RAW_WIDTH + 1),
    localparam int SW  = $clog2(MAX_BLOCK_SIDE + 1),
    localparam int AW  = (MAX_RAW_WIDTH > 1) ? $clog2(MAX_RAW_WIDTH) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [wbd_pkg::RAW_CELL_W-1:0]      raw_cell,
    input  logic                                frame_start,
    input  logic [RCW-1:0]                      eff_w,
    input  logic [SW-1:0]                       eff_s,
    output wbd_pkg::pos_ctrl_t                  ctrl,
    output logic [AW-1:0]                       addr
);
    import wbd_pkg::*;

    localparam int RW = $clog2(MAX_COARSE_ROWS + 1);
    localparam int PW = RCW + 1 + SW;

    logic [RCW-1:0] rc_reg, rc_next;
    logic [SW-1:0]  cib_reg, cib_next;
    logic [SW-1:0]  rib_reg, rib_next;
    logic [RCW-1:0] cc_reg, cc_next;
    logic [RW-1:0]  cr_reg, cr_next;

    logic [RCW-1:0] rc, rc1;
    logic [SW-1:0]  cib, cib1, rib, rib1, s_m1;
    logic [RCW-1:0] cc;
    logic [RW-1:0]  cr;
    logic [RCW:0]   cc_w;
    logic [PW-1:0]  prod;
    logic           in_range;
    logic           row_open;

    always_comb
    begin
        rc   = frame_start ? '0 : rc_reg;
        cib  = frame_start ? '0 : cib_reg;
        rib  = frame_start ? '0 : rib_reg;
        cc   = frame_start ? '0 : cc_reg;
        cr   = frame_start ? '0 : cr_reg;
        s_m1 = eff_s - SW'(1);

        prod     = (PW'(cc) + PW'(1)) * PW'(eff_s);
        in_range = (prod <= PW'(eff_w));
        row_open = (cr < RW'(MAX_COARSE_ROWS));

        ctrl.walk      = (raw_cell != '0);
        ctrl.in_range  = in_range;
        ctrl.first_row = (rib == '0);
        ctrl.emit      = in_range && (rib == s_m1) && (cib == s_m1) && row_open;
        ctrl.x         = COORD_W'(cc);
        ctrl.y         = COORD_W'(cr);
        addr           = cc[AW-1:0];

        rc1      = rc + RCW'(1);
        cib1     = cib + SW'(1);
        rib1     = rib + SW'(1);
        rc_next  = rc1;
        cib_next = cib1;
        rib_next = rib;
        cr_next  = cr;
        cc_w     = {1'b0, cc};
        if (cib1 >= eff_s)
        begin
            cib_next = '0;
            cc_w     = {1'b0, cc} + (RCW + 1)'(1);
        end
        if (rc1 >= eff_w)
        begin
            rc_next  = '0;
            cib_next = '0;
            cc_w     = '0;
            if (rib1 >= eff_s)
            begin
                rib_next = '0;
                if (row_open)
                begin
                    cr_next = cr + RW'(1);
                end
            end
            else
            begin
                rib_next = rib1;
            end
        end
        if (cc_w > (RCW + 1)'(MAX_RAW_WIDTH))
        begin
            cc_next = RCW'(MAX_RAW_WIDTH);
        end
        else
        begin
            cc_next = cc_w[RCW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg  <= '0;
            cib_reg <= '0;
            rib_reg <= '0;
            cc_reg  <= '0;
            cr_reg  <= '0;
        end
        else if (accept)
        begin
            rc_reg  <= rc_next;
            cib_reg <= cib_next;
            rib_reg <= rib_next;
            cc_reg  <= cc_next;
            cr_reg  <= cr_next;
        end
    end

endmodule

>>> sv/wbd_accum.sv
// Column accumulator of the walkability block downsampler.
// Holds the per-column AND memory, its read-modify-write stage with
// forwarding, and the output register. Depends on wbd_pkg.
module wbd_accum #(
    parameter int MAX_RAW_WIDTH = 1024,
    localparam int AW = (MAX_RAW_WIDTH > 1) ? $clog2(MAX_RAW_WIDTH) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  wbd_pkg::pos_ctrl_t           ctrl,
    input  logic [AW-1:0]                addr,
    output logic                         in_ready,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         out_walkable,
    output logic [wbd_pkg::COORD_W-1:0]  out_x,
    output logic [wbd_pkg::COORD_W-1:0]  out_y
);
    import wbd_pkg::*;

    logic mem [MAX_RAW_WIDTH];

    logic              s1_valid_reg, s1_valid_next;
    pos_ctrl_t         s1_ctrl_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic              rdata_reg;
    logic              fwd_valid_reg;
    logic [AW-1:0]     fwd_addr_reg;
    logic              fwd_data_reg;
    logic              out_valid_reg, out_valid_next;
    logic              out_walk_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg;

    logic s1_go, old_bit, acc, wr_en, rd_en, s1_move;

    always_comb
    begin
        s1_go    = !out_valid_reg || out_ready;
        in_ready = !s1_valid_reg || s1_go;
        s1_move  = s1_valid_reg && s1_go;
        old_bit  = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg
                                                                     : rdata_reg;
        acc      = s1_ctrl_reg.walk & (s1_ctrl_reg.first_row | old_bit);
        wr_en    = s1_move && s1_ctrl_reg.in_range;
        rd_en    = accept && ctrl.in_range;

        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_move)
        begin
            out_valid_next = s1_ctrl_reg.emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_addr_reg] <= acc;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctrl_reg <= ctrl;
            s1_addr_reg <= addr;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= acc;
        end
        if (s1_move)
        begin
            out_walk_reg <= acc;
            out_x_reg    <= s1_ctrl_reg.x;
            out_y_reg    <= s1_ctrl_reg.y;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_walkable = out_walk_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;

endmodule

>>> sv/walkability_block_downsample.sv
// Top level of the walkability block downsampler.
// Depends on wbd_pkg, wbd_ifs, wbd_position and wbd_accum.
//
//   Channel  Role    Moves
//   raw      sink    one raw map cell and its frame-start flag per transaction
//   coarse   source  one coarse cell with its coordinates per transaction
//   cfg      sink    one register write (index, data) per transaction
//
// One raw cell is taken in every cycle unless the output stalls. The cell that
// completes a block moves through the read stage, then the output register.
// The pace is set by the read-modify-write of the column memory, which reads
// one entry and writes another per unstalled cycle, the last write forwarded.
// The column memory needs no clearing pass: the first row of each block
// overwrites it. Reset returns both registers to 1 and clears the counters.
// A stalled result holds in the output register; one more raw cell may enter
// behind it before the raw channel stalls.
module walkability_block_downsample #(
    parameter int MAX_RAW_WIDTH   = 1024,
    parameter int MAX_BLOCK_SIDE  = 16,
    parameter int MAX_COARSE_ROWS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    wbd_raw_if.sink     raw,
    wbd_cell_if.source  coarse,
    wbd_cfg_if.sink     cfg
);
    import wbd_pkg::*;

    localparam int RCW = $clog2(MAX_RAW_WIDTH + 1);
    localparam int SW  = $clog2(MAX_BLOCK_SIDE + 1);
    localparam int AW  = (MAX_RAW_WIDTH > 1) ? $clog2(MAX_RAW_WIDTH) : 1;

    logic [RAW_WIDTH_W-1:0] raw_width_reg;
    logic [GRID_STEP_W-1:0] grid_step_reg;
    logic [RCW-1:0]         eff_w;
    logic [SW-1:0]          eff_s;
    logic                   accept;
    logic                   in_ready;
    pos_ctrl_t              ctrl;
    logic [AW-1:0]          addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_width_reg <= RAW_WIDTH_W'(1);
            grid_step_reg <= GRID_STEP_W'(1);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_RAW_WIDTH: raw_width_reg <= cfg.data[RAW_WIDTH_W-1:0];
                REG_GRID_STEP: grid_step_reg <= cfg.data[GRID_STEP_W-1:0];
                default:       raw_width_reg <= raw_width_reg;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    always_comb
    begin
        if (raw_width_reg == '0)
        begin
            eff_w = RCW'(1);
        end
        else if (32'(raw_width_reg) > 32'(MAX_RAW_WIDTH))
        begin
            eff_w = RCW'(MAX_RAW_WIDTH);
        end
        else
        begin
            eff_w = RCW'(raw_width_reg);
        end

        if (grid_step_reg == '0)
        begin
            eff_s = SW'(1);
        end
        else if (32'(grid_step_reg) > 32'(MAX_BLOCK_SIDE))
        begin
            eff_s = SW'(MAX_BLOCK_SIDE);
        end
        else
        begin
            eff_s = SW'(grid_step_reg);
        end
    end

    assign accept    = raw.valid && in_ready;
    assign raw.ready = in_ready;

    wbd_position #(
        .MAX_RAW_WIDTH   (MAX_RAW_WIDTH),
        .MAX_BLOCK_SIDE  (MAX_BLOCK_SIDE),
        .MAX_COARSE_ROWS (MAX_COARSE_ROWS)
    ) u_position (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .raw_cell    (raw.raw_cell),
        .frame_start (raw.frame_start),
        .eff_w       (eff_w),
        .eff_s       (eff_s),
        .ctrl        (ctrl),
        .addr        (addr)
    );

    wbd_accum #(
        .MAX_RAW_WIDTH (MAX_RAW_WIDTH)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .ctrl         (ctrl),
        .addr         (addr),
        .in_ready     (in_ready),
        .out_valid    (coarse.valid),
        .out_ready    (coarse.ready),
        .out_walkable (coarse.cell_walkable),
        .out_x        (coarse.cell_x),
        .out_y        (coarse.cell_y)
    );

endmodule

>>> sv/wbd_checker.sv
// Port-level checker for the walkability block downsampler.
// Sees only the top level's ports and is attached to it by the bind below.
module wbd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        raw_valid,
    input logic        raw_ready,
    input logic        cell_valid,
    input logic        cell_ready,
    input logic        cell_walkable,
    input logic [9:0]  cell_x,
    input logic [9:0]  cell_y
);

    // A stalled result keeps its transaction unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && !cell_ready |=>
            cell_valid && $stable(cell_walkable) && $stable(cell_x) && $stable(cell_y))
        else $error("stalled result changed");

    // With the output register empty the raw channel is never held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        !cell_valid |-> raw_ready)
        else $error("raw channel stalled with empty output");

    // A fresh result comes from a raw cell that did not wait in the read stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cell_valid) |-> $past(raw_valid && raw_ready, 2))
        else $error("result without a matching raw transaction");

endmodule

bind walkability_block_downsample wbd_checker u_wbd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .raw_valid     (raw.valid),
    .raw_ready     (raw.ready),
    .cell_valid    (coarse.valid),
    .cell_ready    (coarse.ready),
    .cell_walkable (coarse.cell_walkable),
    .cell_x        (coarse.cell_x),
    .cell_y        (coarse.cell_y)
);

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for walkability_block_downsample, the min-pooling map reducer.
// Drives raw cells and register writes, then checks each coarse cell against a pooling model.
// Depends on wbd_pkg, the channel interfaces in wbd_ifs and the block itself.
module testbench;
    import wbd_pkg::*;

    localparam int MAX_RAW_WIDTH   = 1024;
    localparam int MAX_BLOCK_SIDE  = 16;
    localparam int MAX_COARSE_ROWS = 1024;
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 4000;
    localparam int TOTAL_ITEMS     = 450;
    localparam int DIRECTED_ROWS   = 27;

    typedef struct packed {
        logic               walkable;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } coarse_t;

    typedef enum logic {ROW_CELL, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
        logic [RAW_CELL_W-1:0]  raw;
        logic                   fs;
        logic                   typed;
        coarse_t                result;
    } stim_row_t;

    typedef enum int {SINK_OPEN, SINK_BUSY, SINK_CHOKED} sink_mode_t;

    logic clk;
    logic rst_n;

    wbd_raw_if  raw_ch ();
    wbd_cell_if cell_ch ();
    wbd_cfg_if  cfg_ch ();

    walkability_block_downsample #(
        .MAX_RAW_WIDTH   (MAX_RAW_WIDTH),
        .MAX_BLOCK_SIDE  (MAX_BLOCK_SIDE),
        .MAX_COARSE_ROWS (MAX_COARSE_ROWS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .raw    (raw_ch),
        .coarse (cell_ch),
        .cfg    (cfg_ch)
    );

    // The first rows run under the reset settings, where every raw cell is a coarse cell.
    stim_row_t directed [DIRECTED_ROWS] = '{
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd0,   1'b1, 1'b1, '{1'b0, 10'd0, 10'd0}},
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd255, 1'b0, 1'b1, '{1'b1, 10'd0, 10'd1}},
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd1,   1'b0, 1'b1, '{1'b1, 10'd0, 10'd2}},
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd128, 1'b1, 1'b1, '{1'b1, 10'd0, 10'd0}},
        '{ROW_REG,  REG_RAW_WIDTH, 11'd0,    8'd0,   1'b0, 1'b0, '{1'b0, 10'd0, 10'd0}},
        '{ROW_REG,  REG_GRID_STEP, 11'h7E0,  8'd0,   1'b0, 1'b0, '{1'b0, 10'd0, 10'd0}},
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd170, 1'b1, 1'b1, '{1'b1, 10'd0, 10'd0}},
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd0,   1'b0, 1'b1, '{1'b0, 10'd0, 10'd1}},
        '{ROW_REG,  REG_RAW_WIDTH, 11'd5,    8'd0,   1'b0, 1'b0, '{1'b0, 10'd0, 10'd0}},
        '{ROW_REG,  REG_GRID_STEP, 11'd2,    8'd0,   1'b0, 1'b0, '{1'b0, 10'd0, 10'd0}},
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd9,   1'b1, 1'b0, '{1'b0, 10'd0, 10'd0}},
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd85,  1'b0, 1'b0, '{1'b0, 10'd0, 10'd0}},
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd0,   1'b0, 1'b0, '{1'b0, 10'd0, 10'd0}},
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd3,   1'b0, 1'b0, '{1'b0, 10'd0, 10'd0}},
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd0,   1'b0, 1'b0, '{1'b0, 10'd0, 10'd0}},
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd4,   1'b0, 1'b0, '{1'b0, 10'd0, 10'd0}},
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd200, 1'b0, 1'b0, '{1'b0, 10'd0, 10'd0}},
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd6,   1'b0, 1'b0, '{1'b0, 10'd0, 10'd0}},
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd7,   1'b0, 1'b0, '{1'b0, 10'd0, 10'd0}},
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd0,   1'b0, 1'b0, '{1'b0, 10'd0, 10'd0}},
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd1,   1'b0, 1'b0, '{1'b0, 10'd0, 10'd0}},
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd1,   1'b0, 1'b0, '{1'b0, 10'd0, 10'd0}},
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd1,   1'b0, 1'b0, '{1'b0, 10'd0, 10'd0}},
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd5,   1'b1, 1'b0, '{1'b0, 10'd0, 10'd0}},
        '{ROW_REG,  REG_RAW_WIDTH, 11'h7FF,  8'd0,   1'b0, 1'b0, '{1'b0, 10'd0, 10'd0}},
        '{ROW_REG,  REG_GRID_STEP, 11'h01F,  8'd0,   1'b0, 1'b0, '{1'b0, 10'd0, 10'd0}},
        '{ROW_CELL, REG_RAW_WIDTH, 11'd0,    8'd255, 1'b1, 1'b0, '{1'b0, 10'd0, 10'd0}}
    };

    logic [RAW_WIDTH_W-1:0] pool_width;
    logic [GRID_STEP_W-1:0] pool_step;
    bit                     and_store [MAX_RAW_WIDTH];
    int unsigned            pos_raw_col;
    int unsigned            pos_col_in_block;
    int unsigned            pos_row_in_block;
    int unsigned            pos_coarse_col;
    int unsigned            pos_coarse_row;

    coarse_t coarse_cells_due[$];

    int  mismatch_count;
    int  raw_sent;
    int  cells_checked;
    int  reg_writes;
    int  settings_run;
    int  burst_left;
    int  quiet_cycles;
    bit  hold_off_due;

    function automatic bit pool_raw_cell(input logic [RAW_CELL_W-1:0] value, input logic fs,
                                         output coarse_t cell_out);
        int unsigned w;
        int unsigned s;
        int unsigned cols;
        bit          walk;
        bit          acc;
        bit          emits;
        cell_out = '0;
        emits = 1'b0;
        w = pool_width;
        if (w == 0) w = 1;
        if (w > MAX_RAW_WIDTH) w = MAX_RAW_WIDTH;
        s = pool_step;
        if (s == 0) s = 1;
        if (s > MAX_BLOCK_SIDE) s = MAX_BLOCK_SIDE;
        cols = w / s;
        walk = (value != 0);
        if (fs) begin
            pos_raw_col = 0;
            pos_col_in_block = 0;
            pos_row_in_block = 0;
            pos_coarse_col = 0;
            pos_coarse_row = 0;
        end
        if (pos_coarse_col < cols && pos_coarse_col < MAX_RAW_WIDTH) begin
            acc = (pos_row_in_block == 0) ? walk : (and_store[pos_coarse_col] & walk);
            and_store[pos_coarse_col] = acc;
            if (pos_row_in_block == s - 1 && pos_col_in_block == s - 1 &&
                pos_coarse_row < MAX_COARSE_ROWS) begin
                cell_out.walkable = acc;
                cell_out.x = COORD_W'(pos_coarse_col);
                cell_out.y = COORD_W'(pos_coarse_row);
                emits = 1'b1;
            end
        end
        pos_raw_col++;
        pos_col_in_block++;
        if (pos_col_in_block >= s) begin
            pos_col_in_block = 0;
            pos_coarse_col++;
        end
        if (pos_raw_col >= w) begin
            pos_raw_col = 0;
            pos_col_in_block = 0;
            pos_coarse_col = 0;
            pos_row_in_block++;
            if (pos_row_in_block >= s) begin
                pos_row_in_block = 0;
                if (pos_coarse_row < MAX_COARSE_ROWS) pos_coarse_row++;
            end
        end
        if (pos_coarse_col > MAX_RAW_WIDTH) pos_coarse_col = MAX_RAW_WIDTH;
        return emits;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40) $display("%0t ns: mismatch, %s", $time, what);
    endtask

    task automatic wait_idle();
        raw_ch.valid <= 1'b0;
        while (coarse_cells_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_RAW_WIDTH) pool_width = value;
        else pool_step = value[GRID_STEP_W-1:0];
        reg_writes++;
    endtask

    task automatic send_cell(input logic [RAW_CELL_W-1:0] value, input logic fs,
                             input logic typed, input coarse_t typed_cell);
        coarse_t due;
        int      gap;
        bit      emits;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                raw_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        raw_ch.raw_cell    <= value;
        raw_ch.frame_start <= fs;
        raw_ch.valid       <= 1'b1;
        do @(posedge clk); while (!raw_ch.ready);
        emits = pool_raw_cell(value, fs, due);
        if (typed) coarse_cells_due.push_back(typed_cell);
        else if (emits) coarse_cells_due.push_back(due);
        raw_sent++;
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] width_data,
                             input logic [CFG_DATA_W-1:0] step_data, input int n_items,
                             input int zero_rate, input int restart_rate, input int restart_at,
                             input bit with_hold_off);
        logic [RAW_CELL_W-1:0] value;
        logic                  fs;
        write_reg(REG_RAW_WIDTH, width_data);
        write_reg(REG_GRID_STEP, step_data);
        settings_run++;
        if (with_hold_off) hold_off_due = 1'b1;
        for (int i = 0; i < n_items; i++) begin
            value = ($urandom_range(1, zero_rate) == 1) ? 8'd0 : 8'($urandom_range(1, 255));
            fs = (i == 0) || (i == restart_at) ||
                 (restart_rate != 0 && $urandom_range(1, restart_rate) == 1);
            send_cell(value, fs, 1'b0, '0);
        end
    endtask

    task automatic run_random_phase(input bit with_hold_off);
        int sel;
        int w;
        int s;
        int s_eff;
        int n;
        sel = $urandom_range(0, 19);
        if (sel < 16) s = $urandom_range(1, 4);
        else if (sel < 18) s = $urandom_range(5, 8);
        else if (sel == 18) s = 0;
        else s = $urandom_range(17, 31);
        if (with_hold_off) s = 1;
        sel = $urandom_range(0, 9);
        if (sel < 7) w = $urandom_range(1, 24);
        else if (sel < 9) w = $urandom_range(25, 200);
        else w = (s > 1) ? s - 1 : 1;
        s_eff = (s == 0) ? 1 : ((s > MAX_BLOCK_SIDE) ? MAX_BLOCK_SIDE : s);
        n = w * s_eff * $urandom_range(1, 3) + $urandom_range(0, w);
        if (n > 150) n = 150;
        if (with_hold_off) n = 60;
        else if (n > TOTAL_ITEMS - raw_sent) n = TOTAL_ITEMS - raw_sent;
        if (n < 1) n = 1;
        run_phase(CFG_DATA_W'(w), {6'($urandom_range(0, 63)), 5'(s)}, n,
                  $urandom_range(2, 40), $urandom_range(0, 1) ? 0 : 60, -1, with_hold_off);
    endtask

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin : cell_sink
        sink_mode_t mode;
        int         mode_left;
        cell_ch.ready <= 1'b0;
        mode = SINK_OPEN;
        mode_left = 0;
        forever begin
            @(posedge clk);
            if (hold_off_due) begin
                hold_off_due = 1'b0;
                cell_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            if (mode_left == 0) begin
                mode = sink_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                SINK_OPEN: cell_ch.ready <= 1'b1;
                SINK_BUSY: cell_ch.ready <= ($urandom_range(0, 3) != 0);
                default:   cell_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk) begin : cell_monitor
        coarse_t want;
        if (rst_n && cell_ch.valid && cell_ch.ready) begin
            cells_checked++;
            if (coarse_cells_due.size() == 0) begin
                report_mismatch($sformatf("coarse cell (%0d,%0d) arrived with none pending",
                                          cell_ch.cell_x, cell_ch.cell_y));
            end
            else begin
                want = coarse_cells_due.pop_front();
                if (cell_ch.cell_walkable !== want.walkable)
                    report_mismatch($sformatf("cell_walkable at (%0d,%0d): got %0b, wanted %0b",
                                              want.x, want.y, cell_ch.cell_walkable,
                                              want.walkable));
                if (cell_ch.cell_x !== want.x)
                    report_mismatch($sformatf("cell_x: got %0d, wanted %0d",
                                              cell_ch.cell_x, want.x));
                if (cell_ch.cell_y !== want.y)
                    report_mismatch($sformatf("cell_y: got %0d, wanted %0d",
                                              cell_ch.cell_y, want.y));
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((raw_ch.valid && raw_ch.ready) || (cell_ch.valid && cell_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles, %0d coarse cells pending",
                         quiet_cycles, coarse_cells_due.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        rst_n              <= 1'b0;
        raw_ch.valid       <= 1'b0;
        raw_ch.raw_cell    <= '0;
        raw_ch.frame_start <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_RAW_WIDTH;
        cfg_ch.data        <= '0;
        pool_width = 1;
        pool_step = 1;
        pos_raw_col = 0;
        pos_col_in_block = 0;
        pos_row_in_block = 0;
        pos_coarse_col = 0;
        pos_coarse_row = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_REG)
                write_reg(directed[i].index, directed[i].data);
            else
                send_cell(directed[i].raw, directed[i].fs, directed[i].typed,
                          directed[i].result);
        end

        run_random_phase(1'b1);
        // The widest block side, with the step register written at or above its range.
        run_phase(CFG_DATA_W'($urandom_range(16, 17)),
                  {6'($urandom_range(0, 63)), 5'($urandom_range(16, 31))},
                  16 * 17 + 5, $urandom_range(300, 1000), 0, -1, 1'b0);
        while (raw_sent < TOTAL_ITEMS) run_random_phase(1'b0);

        wait_idle();
        $display("Run covered %0d raw cells under %0d register settings (%0d writes),",
                 raw_sent, settings_run, reg_writes);
        $display("with %0d coarse cells checked and %0d mismatches.",
                 cells_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
